### rtl/core/cbpf_pkg.sv
`timescale 1ns / 1ps

package cbpf_pkg;

    // field and register widths
    localparam int VAL_W   = 16;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int SIDE_W  = 7;
    localparam int SCALE_W = 24;
    localparam int PIX_W   = 8;

    // smallest cell side and largest side the column field can address
    localparam int SIDE_MIN = 2;
    localparam int COL_LIMIT = 1 << COL_W;
    localparam int SIDE_REG_MAX = (1 << SIDE_W) - 1;

    // register reset values
    localparam logic [SIDE_W-1:0]  SIDE_RESET  = 7'd8;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

    // edge value scaled by height: h * v, below 2^23
    localparam int LN_W  = SIDE_W + VAL_W;
    localparam int LNS_W = LN_W + 1;
    // pixel numerator scaled by height and width
    localparam int PN_W  = LN_W + COL_W;
    localparam int ACC_W = PN_W + 1;
    // denominator h * w
    localparam int DEN_W = SIDE_W + COL_W;

    // split of the scale multiply into two partial products
    localparam int PN_LO_W = 15;
    localparam int PN_HI_W = PN_W - PN_LO_W;
    localparam int PPL_W   = SCALE_W + PN_LO_W;
    localparam int PPH_W   = SCALE_W + PN_HI_W;
    localparam int NUM_W   = SCALE_W + PN_W;

    // fraction bits of the Q8.16 scale
    localparam int FRAC_W = 16;
    localparam int MDEN_W = DEN_W + FRAC_W;

    // quotient bits and saturation point
    localparam int Q_W = 8;
    localparam logic [PIX_W-1:0] GRAY_OFFSET = 8'd4;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [Q_W-1:0] SAT_Q = 8'd252;
    localparam int THR_W = MDEN_W + Q_W;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_CELL_WIDTH    = 2'd0,
        CFG_CELL_HEIGHT   = 2'd1,
        CFG_GRAY_SCALE    = 2'd2,
        CFG_INTERP_ENABLE = 2'd3
    } t_cfg_reg;

    // one pixel beat from the row generator into the gray pipe
    typedef struct packed {
        logic [PN_W-1:0]    pn;
        logic [SCALE_W-1:0] scale;
        logic [DEN_W-1:0]   den;
        logic [COL_W-1:0]   column;
        logic               last;
    } t_px_beat;

endpackage

### rtl/core/cbpf_gray_pipe.sv
`timescale 1ns / 1ps

module cbpf_gray_pipe (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  cbpf_pkg::t_px_beat        i_beat,
    output logic                      o_ready,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [cbpf_pkg::PIX_W-1:0] o_pixel,
    output logic [cbpf_pkg::COL_W-1:0] o_column,
    output logic                      o_last
);

    localparam int PN_LO_W = cbpf_pkg::PN_LO_W;
    localparam int PN_W    = cbpf_pkg::PN_W;
    localparam int PPL_W   = cbpf_pkg::PPL_W;
    localparam int PPH_W   = cbpf_pkg::PPH_W;
    localparam int NUM_W   = cbpf_pkg::NUM_W;
    localparam int MDEN_W  = cbpf_pkg::MDEN_W;
    localparam int THR_W   = cbpf_pkg::THR_W;
    localparam int DEN_W   = cbpf_pkg::DEN_W;
    localparam int COL_W   = cbpf_pkg::COL_W;
    localparam int Q_W     = cbpf_pkg::Q_W;
    localparam int FRAC_W  = cbpf_pkg::FRAC_W;
    localparam int DV_STEPS = Q_W;

    // whole pipe moves together when the output register can take a beat
    logic w_en;
    assign w_en    = !o_valid || !i_stall;
    assign o_ready = w_en;

    // stage 1: partial products of scale times numerator
    logic                r_m1_v;
    logic [PPL_W-1:0]    r_m1_pl;
    logic [PPH_W-1:0]    r_m1_ph;
    logic [DEN_W-1:0]    r_m1_den;
    logic [COL_W-1:0]    r_m1_col;
    logic                r_m1_last;

    // stage 2: full product, shifted divisor and saturation threshold
    logic                r_m2_v;
    logic [NUM_W-1:0]    r_m2_num;
    logic [MDEN_W-1:0]   r_m2_mden;
    logic [THR_W-1:0]    r_m2_thr;
    logic [COL_W-1:0]    r_m2_col;
    logic                r_m2_last;

    // divide stages: entry 0 holds the saturation test, then one quotient bit each
    logic                r_dv_v    [0:DV_STEPS];
    logic [NUM_W-1:0]    r_dv_rem  [0:DV_STEPS];
    logic [MDEN_W-1:0]   r_dv_mden [0:DV_STEPS];
    logic [Q_W-1:0]      r_dv_q    [0:DV_STEPS];
    logic                r_dv_sat  [0:DV_STEPS];
    logic [COL_W-1:0]    r_dv_col  [0:DV_STEPS];
    logic                r_dv_last [0:DV_STEPS];

    // output register
    logic                      r_out_v;
    logic [cbpf_pkg::PIX_W-1:0] r_out_pix;
    logic [COL_W-1:0]          r_out_col;
    logic                      r_out_last;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v     <= 1'b0;
            r_m2_v     <= 1'b0;
            r_dv_v[0]  <= 1'b0;
            r_out_v    <= 1'b0;
        end else if (w_en) begin
            r_m1_v     <= i_valid;
            r_m2_v     <= r_m1_v;
            r_dv_v[0]  <= r_m2_v;
            r_out_v    <= r_dv_v[DV_STEPS];
        end
    end

    // multiply, sum and threshold stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_pl   <= PPL_W'(i_beat.scale) * PPL_W'(i_beat.pn[PN_LO_W-1:0]);
            r_m1_ph   <= PPH_W'(i_beat.scale) * PPH_W'(i_beat.pn[PN_W-1:PN_LO_W]);
            r_m1_den  <= i_beat.den;
            r_m1_col  <= i_beat.column;
            r_m1_last <= i_beat.last;

            r_m2_num  <= NUM_W'(r_m1_pl) + (NUM_W'(r_m1_ph) << PN_LO_W);
            r_m2_mden <= {r_m1_den, {FRAC_W{1'b0}}};
            r_m2_thr  <= THR_W'({r_m1_den, {FRAC_W{1'b0}}}) * THR_W'(cbpf_pkg::SAT_Q);
            r_m2_col  <= r_m1_col;
            r_m2_last <= r_m1_last;

            r_dv_rem[0]  <= r_m2_num;
            r_dv_mden[0] <= r_m2_mden;
            r_dv_q[0]    <= '0;
            r_dv_sat[0]  <= r_m2_num >= NUM_W'(r_m2_thr);
            r_dv_col[0]  <= r_m2_col;
            r_dv_last[0] <= r_m2_last;
        end
    end

    // restoring divide, most significant quotient bit first
    for (genvar k = 1; k <= DV_STEPS; k++) begin : g_dv
        logic [NUM_W-1:0] w_sub;
        logic             w_take;
        assign w_sub  = NUM_W'(r_dv_mden[k-1]) << (DV_STEPS - k);
        assign w_take = r_dv_rem[k-1] >= w_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[k] <= r_dv_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_rem[k]  <= w_take ? r_dv_rem[k-1] - w_sub : r_dv_rem[k-1];
                r_dv_q[k]    <= w_take ? r_dv_q[k-1] | (Q_W'(1) << (DV_STEPS - k))
                                       : r_dv_q[k-1];
                r_dv_mden[k] <= r_dv_mden[k-1];
                r_dv_sat[k]  <= r_dv_sat[k-1];
                r_dv_col[k]  <= r_dv_col[k-1];
                r_dv_last[k] <= r_dv_last[k-1];
            end
        end
    end

    // offset and saturate into the gray byte
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_pix  <= r_dv_sat[DV_STEPS] ? cbpf_pkg::PIX_MAX
                                             : r_dv_q[DV_STEPS] + cbpf_pkg::GRAY_OFFSET;
            r_out_col  <= r_dv_col[DV_STEPS];
            r_out_last <= r_dv_last[DV_STEPS];
        end
    end

    assign o_valid  = r_out_v;
    assign o_pixel  = r_out_pix;
    assign o_column = r_out_col;
    assign o_last   = r_out_last;

    // an unsaturated quotient stays below the saturation point
    a_q_below_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_v[DV_STEPS] && !r_dv_sat[DV_STEPS]) |-> (r_dv_q[DV_STEPS] < cbpf_pkg::SAT_Q))
        else $error("quotient reached saturation point without sat flag");

    // a stalled output freezes the divide tail
    a_tail_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_stall) |=> ($stable(r_dv_v[DV_STEPS]) && $stable(r_dv_q[DV_STEPS])))
        else $error("divide stage moved while output stalled");

    // a stalled output beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pixel) && $stable(o_column)
                                  && $stable(o_last)))
        else $error("output beat changed while stalled");

endmodule

### rtl/core/cell_bilinear_pixel_fill.sv
// Bilinear cell row fill. Each input beat carries the four corner intensities of a cell and
// a row number; the block returns that row's gray pixels, one beat per column from column 0,
// with last_in_row set on the final column. Width and height are clamped to the range the
// block supports and a row past the bottom reads as the last row. With interp_enable low or
// all corners equal the row is flat at the first corner. The row generator emits one pixel
// per cycle while the gray pipe is not stalled, so an item occupies the generator for its
// clamped cell_width columns (2 to 64), and the next item's edge values are prepared in a
// three stage front end meanwhile. An accepted item's pixels pass through the three front end
// stages, the row generator, and a twelve stage gray pipe (two multiply stages, a saturation
// test, eight restoring divide steps by height times width, and the output register).
`timescale 1ns / 1ps

module cell_bilinear_pixel_fill #(
    parameter int MAX_CELL_SIDE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_corner_origin,
    input  logic [15:0] i_corner_far_x,
    input  logic [15:0] i_corner_far_xy,
    input  logic [15:0] i_corner_far_y,
    input  logic [5:0]  i_row_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_pixel,
    output logic [5:0]  o_column,
    output logic        o_last_in_row
);

    localparam int SW      = cbpf_pkg::SIDE_W;
    localparam int VW      = cbpf_pkg::VAL_W;
    localparam int RW      = cbpf_pkg::ROW_W;
    localparam int CW      = cbpf_pkg::COL_W;
    localparam int SCW     = cbpf_pkg::SCALE_W;
    localparam int LN_W    = cbpf_pkg::LN_W;
    localparam int LNS_W   = cbpf_pkg::LNS_W;
    localparam int PN_W    = cbpf_pkg::PN_W;
    localparam int ACC_W   = cbpf_pkg::ACC_W;
    localparam int DEN_W   = cbpf_pkg::DEN_W;

    localparam int W_HI_I = (MAX_CELL_SIDE < cbpf_pkg::COL_LIMIT) ? MAX_CELL_SIDE
                                                                  : cbpf_pkg::COL_LIMIT;
    localparam int H_HI_I = (MAX_CELL_SIDE < cbpf_pkg::SIDE_REG_MAX) ? MAX_CELL_SIDE
                                                                     : cbpf_pkg::SIDE_REG_MAX;
    localparam logic [SW-1:0] W_HI   = SW'(W_HI_I);
    localparam logic [SW-1:0] H_HI   = SW'(H_HI_I);
    localparam logic [SW-1:0] S_MIN  = SW'(cbpf_pkg::SIDE_MIN);

    // configuration registers
    logic [SW-1:0]  r_cfg_w;
    logic [SW-1:0]  r_cfg_h;
    logic [SCW-1:0] r_cfg_s;
    logic           r_cfg_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= cbpf_pkg::SIDE_RESET;
            r_cfg_h  <= cbpf_pkg::SIDE_RESET;
            r_cfg_s  <= cbpf_pkg::SCALE_RESET;
            r_cfg_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (cbpf_pkg::t_cfg_reg'(i_cfg_idx))
                cbpf_pkg::CFG_CELL_WIDTH:    r_cfg_w  <= i_cfg_data[SW-1:0];
                cbpf_pkg::CFG_CELL_HEIGHT:   r_cfg_h  <= i_cfg_data[SW-1:0];
                cbpf_pkg::CFG_GRAY_SCALE:    r_cfg_s  <= i_cfg_data[SCW-1:0];
                cbpf_pkg::CFG_INTERP_ENABLE: r_cfg_en <= i_cfg_data[0];
            endcase
        end
    end

    // clamped cell sides and row
    logic [SW-1:0] w_wc;
    logic [SW-1:0] w_hc;
    logic [SW-1:0] w_hm1;
    logic [RW-1:0] w_yc;
    logic          w_ylast;
    logic          w_flat;
    logic signed [VW:0] w_dl;
    logic signed [VW:0] w_dr;

    always_comb begin
        w_wc = (r_cfg_w < S_MIN) ? S_MIN : ((r_cfg_w > W_HI) ? W_HI : r_cfg_w);
        w_hc = (r_cfg_h < S_MIN) ? S_MIN : ((r_cfg_h > H_HI) ? H_HI : r_cfg_h);
        w_hm1 = w_hc - SW'(1);
        w_yc = (SW'(i_row_index) >= w_hc) ? w_hm1[RW-1:0] : i_row_index;
        w_ylast = (SW'(w_yc) == w_hm1);
        w_flat = !r_cfg_en || ((i_corner_origin == i_corner_far_x) &&
                               (i_corner_far_x == i_corner_far_xy) &&
                               (i_corner_far_xy == i_corner_far_y));
        w_dl = $signed({1'b0, i_corner_far_y}) - $signed({1'b0, i_corner_origin});
        w_dr = $signed({1'b0, i_corner_far_xy}) - $signed({1'b0, i_corner_far_x});
    end

    // front end handshake
    logic r_i1_v, r_i2_v, r_i3_v;
    logic w_rdy1, w_rdy2, w_rdy3;
    logic w_gen_load;

    assign w_rdy3  = !r_i3_v || w_gen_load;
    assign w_rdy2  = !r_i2_v || w_rdy3;
    assign w_rdy1  = !r_i1_v || w_rdy2;
    assign o_stall = !w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i1_v <= 1'b0;
            r_i2_v <= 1'b0;
            r_i3_v <= 1'b0;
        end else begin
            if (w_rdy1) r_i1_v <= i_valid;
            if (w_rdy2) r_i2_v <= r_i1_v;
            if (w_rdy3) r_i3_v <= r_i2_v;
        end
    end

    // stage 1: products of height and row with the corners
    logic [LN_W-1:0]         r_i1_al, r_i1_ar;
    logic signed [LNS_W-1:0] r_i1_bl, r_i1_br;
    logic [SW-1:0]           r_i1_w, r_i1_h;
    logic [SCW-1:0]          r_i1_s;
    logic                    r_i1_flat;
    logic [VW-1:0]           r_i1_v1;

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_i1_al   <= LN_W'(w_hc) * LN_W'(w_ylast ? i_corner_far_y : i_corner_origin);
            r_i1_ar   <= LN_W'(w_hc) * LN_W'(w_ylast ? i_corner_far_xy : i_corner_far_x);
            r_i1_bl   <= w_ylast ? '0 : LNS_W'($signed({1'b0, w_yc})) * LNS_W'(w_dl);
            r_i1_br   <= w_ylast ? '0 : LNS_W'($signed({1'b0, w_yc})) * LNS_W'(w_dr);
            r_i1_w    <= w_wc;
            r_i1_h    <= w_hc;
            r_i1_s    <= r_cfg_s;
            r_i1_flat <= w_flat;
            r_i1_v1   <= i_corner_origin;
        end
    end

    // stage 2: edge values scaled by height
    logic [LN_W-1:0]         r_i2_ln, r_i2_rn;
    logic [SW-1:0]           r_i2_w, r_i2_h;
    logic [SCW-1:0]          r_i2_s;
    logic                    r_i2_flat;
    logic [VW-1:0]           r_i2_v1;
    logic signed [LNS_W-1:0] w_ln_s, w_rn_s;

    assign w_ln_s = $signed({1'b0, r_i1_al}) + r_i1_bl;
    assign w_rn_s = $signed({1'b0, r_i1_ar}) + r_i1_br;

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_i2_ln   <= w_ln_s[LN_W-1:0];
            r_i2_rn   <= w_rn_s[LN_W-1:0];
            r_i2_w    <= r_i1_w;
            r_i2_h    <= r_i1_h;
            r_i2_s    <= r_i1_s;
            r_i2_flat <= r_i1_flat;
            r_i2_v1   <= r_i1_v1;
        end
    end

    // stage 3: row endpoints scaled by width, column step and denominator
    logic [PN_W-1:0]         r_i3_wln, r_i3_wrn;
    logic signed [LNS_W-1:0] r_i3_d;
    logic [DEN_W-1:0]        r_i3_den;
    logic [SCW-1:0]          r_i3_s;
    logic [CW-1:0]           r_i3_wlast;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            if (r_i2_flat) begin
                r_i3_wln <= PN_W'(r_i2_v1);
                r_i3_wrn <= PN_W'(r_i2_v1);
                r_i3_d   <= '0;
                r_i3_den <= DEN_W'(1);
            end else begin
                r_i3_wln <= PN_W'(r_i2_w) * PN_W'(r_i2_ln);
                r_i3_wrn <= PN_W'(r_i2_w) * PN_W'(r_i2_rn);
                r_i3_d   <= $signed({1'b0, r_i2_rn}) - $signed({1'b0, r_i2_ln});
                r_i3_den <= DEN_W'(r_i2_h) * DEN_W'(r_i2_w);
            end
            r_i3_s     <= r_i2_s;
            r_i3_wlast <= CW'(r_i2_w - SW'(1));
        end
    end

    // row generator: one column per beat, numerator stepped by the column delta
    logic                    r_g_busy;
    logic signed [ACC_W-1:0] r_g_acc;
    logic signed [LNS_W-1:0] r_g_d;
    logic [PN_W-1:0]         r_g_wrn;
    logic [DEN_W-1:0]        r_g_den;
    logic [SCW-1:0]          r_g_s;
    logic [CW-1:0]           r_g_wlast;
    logic [CW-1:0]           r_g_col;

    logic               w_gray_rdy;
    logic               w_is_last;
    logic               w_beat;
    cbpf_pkg::t_px_beat w_px;

    assign w_is_last  = (r_g_col == r_g_wlast);
    assign w_beat     = r_g_busy && w_gray_rdy;
    assign w_gen_load = !r_g_busy || (w_gray_rdy && w_is_last);

    always_comb begin
        w_px.pn     = w_is_last ? r_g_wrn : r_g_acc[PN_W-1:0];
        w_px.scale  = r_g_s;
        w_px.den    = r_g_den;
        w_px.column = r_g_col;
        w_px.last   = w_is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_busy <= 1'b0;
        end else if (w_gen_load) begin
            r_g_busy <= r_i3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_gen_load) begin
            r_g_acc   <= $signed({1'b0, r_i3_wln});
            r_g_d     <= r_i3_d;
            r_g_wrn   <= r_i3_wrn;
            r_g_den   <= r_i3_den;
            r_g_s     <= r_i3_s;
            r_g_wlast <= r_i3_wlast;
            r_g_col   <= '0;
        end else if (w_beat) begin
            r_g_acc   <= r_g_acc + ACC_W'(r_g_d);
            r_g_col   <= r_g_col + CW'(1);
        end
    end

    // gray scaling, divide and output register
    cbpf_gray_pipe u_gray (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_g_busy),
        .i_beat   (w_px),
        .o_ready  (w_gray_rdy),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_pixel  (o_pixel),
        .o_column (o_column),
        .o_last   (o_last_in_row)
    );

    // column counter stays inside the row
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_g_busy |-> (r_g_col <= r_g_wlast))
        else $error("row generator column past end of row");

    // last column frees the generator when no item waits
    a_row_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_beat && w_is_last && !r_i3_v) |=> !r_g_busy)
        else $error("generator still busy after last column");

    // a held generator keeps its column
    a_gen_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_g_busy && !w_gray_rdy) |=> (r_g_busy && $stable(r_g_col)))
        else $error("generator moved while gray pipe stalled");

endmodule
